[rtl/yuyv_pkg.sv]
package yuyv_pkg;

	// Width of a sample and of a channel
	localparam int unsigned PIX_W = 8;

	// Working width of the Q.16 channel sum: luma << 16 plus two chroma terms
	localparam int unsigned SUM_W = 27;

	// Width of the dimming product (255 * 220 fits in 16 bits)
	localparam int unsigned DIM_W = 16;

	localparam int unsigned FRAC_W = 16;

	// Q1.16 chroma weights; the green ones are negated so every channel is a plain sum
	localparam logic signed [SUM_W-1:0] COEF_R_V = 27'sd89830;
	localparam logic signed [SUM_W-1:0] COEF_G_V = -27'sd45744;
	localparam logic signed [SUM_W-1:0] COEF_G_U = -27'sd22127;
	localparam logic signed [SUM_W-1:0] COEF_B_U = 27'sd113538;

	localparam logic [PIX_W-1:0] CHAN_MAX = 8'd255;
	localparam logic [PIX_W-1:0] DIM_MUL  = 8'd220;

	typedef logic [PIX_W-1:0] pix_t;
	typedef logic signed [SUM_W-1:0] sum_t;
	typedef logic [DIM_W-1:0] dim_t;

	// Pipeline control shared by the channel slices
	typedef struct packed {
		logic en;
	} pipe_ctl_t;

endpackage

[rtl/yuyv_in_if.sv]
interface yuyv_in_if;
	logic valid;
	logic ready;
	yuyv_pkg::pix_t luma_first;
	yuyv_pkg::pix_t chroma_blue;
	yuyv_pkg::pix_t luma_second;
	yuyv_pkg::pix_t chroma_red;
	logic frame_end_in;

	modport source (
		output valid, luma_first, chroma_blue, luma_second, chroma_red, frame_end_in,
		input ready
	);
	modport sink (
		input valid, luma_first, chroma_blue, luma_second, chroma_red, frame_end_in,
		output ready
	);
endinterface

[rtl/yuyv_out_if.sv]
interface yuyv_out_if;
	logic valid;
	logic ready;
	yuyv_pkg::pix_t red_first;
	yuyv_pkg::pix_t green_first;
	yuyv_pkg::pix_t blue_first;
	yuyv_pkg::pix_t red_second;
	yuyv_pkg::pix_t green_second;
	yuyv_pkg::pix_t blue_second;
	logic frame_end_out;

	modport source (
		output valid, red_first, green_first, blue_first,
		red_second, green_second, blue_second, frame_end_out,
		input ready
	);
	modport sink (
		input valid, red_first, green_first, blue_first,
		red_second, green_second, blue_second, frame_end_out,
		output ready
	);
endinterface

[rtl/yuyv_chan.sv]
// One color channel, stages 2 and 3: sum and clamp, then dim.
module yuyv_chan (
	input  logic                clk,
	input  yuyv_pkg::pipe_ctl_t ctl,
	input  yuyv_pkg::pix_t      luma,
	input  yuyv_pkg::sum_t      term_a,
	input  yuyv_pkg::sum_t      term_b,
	output yuyv_pkg::pix_t      chan
);

	yuyv_pkg::sum_t sum;
	yuyv_pkg::pix_t clamp;
	yuyv_pkg::pix_t clamp_s2;
	yuyv_pkg::dim_t dim_s3;

	always_comb begin
		sum = $signed({3'b000, luma, {yuyv_pkg::FRAC_W{1'b0}}}) + term_a + term_b;
		if (sum[yuyv_pkg::SUM_W-1]) begin
			clamp = '0;
		end else if (sum[yuyv_pkg::SUM_W-2:yuyv_pkg::FRAC_W+yuyv_pkg::PIX_W] != '0) begin
			clamp = yuyv_pkg::CHAN_MAX;
		end else begin
			clamp = sum[yuyv_pkg::FRAC_W+yuyv_pkg::PIX_W-1:yuyv_pkg::FRAC_W];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			clamp_s2 <= clamp;
			dim_s3   <= yuyv_pkg::dim_t'(clamp_s2) * yuyv_pkg::dim_t'(yuyv_pkg::DIM_MUL);
		end
	end

	// Drop the low byte of the dimming product
	assign chan = dim_s3[yuyv_pkg::DIM_W-1:yuyv_pkg::DIM_W-yuyv_pkg::PIX_W];

endmodule

[rtl/yuyv_to_rgb_scaled.sv]
// YUYV 4:2:2 to dimmed RGB888 converter. Each word on yuv carries two luma samples
// and one shared chroma pair; each word on rgb carries the two matching RGB pixels,
// every channel clamped to 0..255 and then scaled by 220/256, so it lies in 0..219.
// The end-of-frame flag rides along unchanged. The block keeps no state between
// words and takes one word per clock while rgb is not stalled. Stage 1 forms the
// chroma products, stage 2 adds the luma and clamps, stage 3 applies the dimming
// multiply and is the output register. The whole pipe advances whenever the output
// register is empty or being taken, so a stall on rgb holds every stage in place.
module yuyv_to_rgb_scaled (
	input  logic           clk,
	input  logic           arst_n,
	yuyv_in_if.sink        yuv,
	yuyv_out_if.source     rgb
);

	yuyv_pkg::pipe_ctl_t ctl;

	logic v_s1, v_s2, v_s3;
	logic fe_s1, fe_s2, fe_s3;

	yuyv_pkg::sum_t cb;
	yuyv_pkg::sum_t cr;

	yuyv_pkg::pix_t y0_s1, y1_s1;
	yuyv_pkg::sum_t rv_s1, gv_s1, gu_s1, bu_s1;

	// Advance the pipe when the output register is free or its word leaves
	assign ctl.en    = !v_s3 || rgb.ready;
	assign yuv.ready = ctl.en;

	// Remove the chroma bias: flip the top bit and sign extend
	assign cb = yuyv_pkg::sum_t'($signed({~yuv.chroma_blue[7], yuv.chroma_blue[6:0]}));
	assign cr = yuyv_pkg::sum_t'($signed({~yuv.chroma_red[7], yuv.chroma_red[6:0]}));

	// Valid bits and the frame flag travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (ctl.en) begin
			v_s1 <= yuv.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Stage 1: chroma products, shared by both pixels, and the two luma samples
	always_ff @(posedge clk) begin
		if (ctl.en) begin
			fe_s1 <= yuv.frame_end_in;
			fe_s2 <= fe_s1;
			fe_s3 <= fe_s2;
			y0_s1 <= yuv.luma_first;
			y1_s1 <= yuv.luma_second;
			rv_s1 <= cr * yuyv_pkg::COEF_R_V;
			gv_s1 <= cr * yuyv_pkg::COEF_G_V;
			gu_s1 <= cb * yuyv_pkg::COEF_G_U;
			bu_s1 <= cb * yuyv_pkg::COEF_B_U;
		end
	end

	// Stages 2 and 3, one slice per channel
	yuyv_chan u_r0 (.clk(clk), .ctl(ctl), .luma(y0_s1), .term_a(rv_s1), .term_b('0),
		.chan(rgb.red_first));
	yuyv_chan u_g0 (.clk(clk), .ctl(ctl), .luma(y0_s1), .term_a(gv_s1), .term_b(gu_s1),
		.chan(rgb.green_first));
	yuyv_chan u_b0 (.clk(clk), .ctl(ctl), .luma(y0_s1), .term_a(bu_s1), .term_b('0),
		.chan(rgb.blue_first));
	yuyv_chan u_r1 (.clk(clk), .ctl(ctl), .luma(y1_s1), .term_a(rv_s1), .term_b('0),
		.chan(rgb.red_second));
	yuyv_chan u_g1 (.clk(clk), .ctl(ctl), .luma(y1_s1), .term_a(gv_s1), .term_b(gu_s1),
		.chan(rgb.green_second));
	yuyv_chan u_b1 (.clk(clk), .ctl(ctl), .luma(y1_s1), .term_a(bu_s1), .term_b('0),
		.chan(rgb.blue_second));

	assign rgb.valid         = v_s3;
	assign rgb.frame_end_out = fe_s3;

endmodule

[verif/tb_yuyv_to_rgb_scaled.sv]
`timescale 1ns / 100ps

module tb_yuyv_to_rgb_scaled;

	// Chroma weights in Q1.16; the green ones are subtracted from the luma
	localparam int W_RED_V    = 89830;
	localparam int W_GREEN_V  = 45744;
	localparam int W_GREEN_U  = 22127;
	localparam int W_BLUE_U   = 113538;
	localparam int CHROMA_MID = 128;
	localparam int LEVEL_MAX  = 255;
	localparam int DIM_GAIN   = 220;

	// Three pipe stages; leave spare idle cycles after the last rgb word
	localparam int TAIL_CYCLES = 8;
	// Long output stall that backs up the whole pipe
	localparam int HOLD_CYCLES = 150;
	// Cycles without any accepted word before the run is declared hung
	localparam int STALL_LIMIT = 2000;

	typedef struct packed {
		yuyv_pkg::pix_t luma_first;
		yuyv_pkg::pix_t chroma_blue;
		yuyv_pkg::pix_t luma_second;
		yuyv_pkg::pix_t chroma_red;
		logic frame_end;
	} yuyv_word_t;

	typedef struct packed {
		yuyv_pkg::pix_t red_first;
		yuyv_pkg::pix_t green_first;
		yuyv_pkg::pix_t blue_first;
		yuyv_pkg::pix_t red_second;
		yuyv_pkg::pix_t green_second;
		yuyv_pkg::pix_t blue_second;
		logic frame_end;
	} rgb_pair_t;

	logic clk = 1'b0;
	logic arst_n;

	yuyv_in_if  yuv ();
	yuyv_out_if rgb ();

	// Pixel pairs predicted from accepted yuv words, oldest first
	rgb_pair_t expected_pairs[$];

	int error_count   = 0;
	int src_idle_pct  = 30;
	int sink_idle_pct = 30;
	int sink_hold_req = 0;
	int quiet_cycles  = 0;

	yuyv_to_rgb_scaled i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.yuv    (yuv),
		.rgb    (rgb)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Floor the Q.16 sum, clamp to 0..255, then dim by 220/256.
	// A negative sum goes straight to zero.
	function automatic yuyv_pkg::pix_t dim_level(input int sum_q16);
		int level;
		if (sum_q16 < 0)
			return '0;
		level = sum_q16 >>> 16;
		if (level > LEVEL_MAX)
			level = LEVEL_MAX;
		return yuyv_pkg::pix_t'((level * DIM_GAIN) >> 8);
	endfunction

	// Both pixels share the chroma pair; only the luma differs.
	function automatic rgb_pair_t convert_word(input yuyv_word_t w);
		int u;
		int v;
		int base_first;
		int base_second;
		rgb_pair_t p;
		u = int'(w.chroma_blue) - CHROMA_MID;
		v = int'(w.chroma_red) - CHROMA_MID;
		base_first  = int'(w.luma_first) * 65536;
		base_second = int'(w.luma_second) * 65536;
		p.red_first    = dim_level(base_first + W_RED_V * v);
		p.green_first  = dim_level(base_first - W_GREEN_V * v - W_GREEN_U * u);
		p.blue_first   = dim_level(base_first + W_BLUE_U * u);
		p.red_second   = dim_level(base_second + W_RED_V * v);
		p.green_second = dim_level(base_second - W_GREEN_V * v - W_GREEN_U * u);
		p.blue_second  = dim_level(base_second + W_BLUE_U * u);
		p.frame_end    = w.frame_end;
		return p;
	endfunction

	function automatic yuyv_word_t make_word(input int y0, input int u, input int y1,
			input int v, input logic fe);
		yuyv_word_t w;
		w.luma_first  = yuyv_pkg::pix_t'(y0);
		w.chroma_blue = yuyv_pkg::pix_t'(u);
		w.luma_second = yuyv_pkg::pix_t'(y1);
		w.chroma_red  = yuyv_pkg::pix_t'(v);
		w.frame_end   = fe;
		return w;
	endfunction

	// Lean toward the extremes and the chroma midpoint so clamping shows up often
	function automatic yuyv_pkg::pix_t pick_sample();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			2: return yuyv_pkg::pix_t'(CHROMA_MID);
			default: return yuyv_pkg::pix_t'($urandom);
		endcase
	endfunction

	function automatic yuyv_word_t random_word();
		yuyv_word_t w;
		w.luma_first  = pick_sample();
		w.chroma_blue = pick_sample();
		w.luma_second = pick_sample();
		w.chroma_red  = pick_sample();
		w.frame_end   = ($urandom_range(15) == 0);
		return w;
	endfunction

	task automatic report_error(input string msg);
		$display("ERROR %0t: %s", $time, msg);
		error_count++;
	endtask

	task automatic check_channel(input string name, input yuyv_pkg::pix_t got,
			input yuyv_pkg::pix_t want);
		if (got !== want)
			report_error($sformatf("%s got %0d expected %0d", name, got, want));
	endtask

	// Offer one yuv word and hold it until the block takes it. Valid stays high
	// on return so a following word goes out back to back.
	task automatic send_word(input yuyv_word_t w);
		if ($urandom_range(99) < src_idle_pct) begin
			yuv.valid <= 1'b0;
			repeat ($urandom_range(6, 1)) @(posedge clk);
		end
		yuv.luma_first   <= w.luma_first;
		yuv.chroma_blue  <= w.chroma_blue;
		yuv.luma_second  <= w.luma_second;
		yuv.chroma_red   <= w.chroma_red;
		yuv.frame_end_in <= w.frame_end;
		yuv.valid        <= 1'b1;
		@(posedge clk);
		while (!yuv.ready)
			@(posedge clk);
	endtask

	// Drop valid and wait until every predicted pair has come out
	task automatic drain_pipeline();
		yuv.valid <= 1'b0;
		@(posedge clk);
		while (expected_pairs.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// Extremes, clamping on every channel in both directions, alternating bits
	task automatic test_corner_words();
		send_word(make_word(0, 128, 255, 128, 1'b0));     // neutral chroma, black and white
		send_word(make_word(0, 0, 0, 0, 1'b0));
		send_word(make_word(255, 255, 255, 255, 1'b1));
		send_word(make_word(255, 128, 255, 255, 1'b0));   // red saturates
		send_word(make_word(0, 128, 0, 0, 1'b0));         // red goes negative
		send_word(make_word(0, 255, 0, 255, 1'b0));       // green goes negative
		send_word(make_word(255, 0, 255, 0, 1'b0));       // green saturates
		send_word(make_word(255, 255, 0, 128, 1'b0));     // blue saturates
		send_word(make_word(0, 0, 255, 128, 1'b0));       // blue goes negative
		send_word(make_word(128, 127, 129, 129, 1'b1));   // chroma one step off midpoint
		send_word(make_word(16, 128, 235, 128, 1'b0));
		send_word(make_word(1, 1, 254, 254, 1'b0));
		send_word(make_word(128, 128, 128, 128, 1'b1));
		send_word(make_word(170, 85, 85, 170, 1'b0));
		send_word(make_word(85, 170, 170, 85, 1'b1));
		send_word(make_word(200, 64, 50, 192, 1'b0));
		drain_pipeline();
	endtask

	// Full rate on both sides: no gaps, no stalls
	task automatic test_back_to_back(input int count);
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		repeat (count) send_word(random_word());
		drain_pipeline();
		src_idle_pct  = 30;
		sink_idle_pct = 30;
	endtask

	// Hold rgb off for a long stretch while yuv keeps offering; the pipe fills
	// and must stall its input without losing or repeating a word.
	task automatic test_output_hold(input int count);
		src_idle_pct  = 0;
		sink_hold_req = HOLD_CYCLES;
		repeat (count) send_word(random_word());
		drain_pipeline();
		src_idle_pct = 30;
	endtask

	task automatic test_random_words(input int count);
		repeat (count) send_word(random_word());
		drain_pipeline();
	endtask

	// Drive rgb ready: random stalls, or a counted hold when one is requested
	initial begin : sink_ready_drive
		int hold_left;
		hold_left = 0;
		rgb.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (sink_hold_req > 0) begin
				hold_left     = sink_hold_req;
				sink_hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				rgb.ready <= 1'b0;
			end else begin
				rgb.ready <= ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	// Check the rgb word first: a word taken at this same edge cannot have
	// produced it, so it must not be in the queue yet.
	always @(posedge clk) begin : pair_check
		rgb_pair_t  want;
		yuyv_word_t taken;
		if (arst_n) begin
			if (rgb.valid && rgb.ready) begin
				if (expected_pairs.size() == 0) begin
					report_error("rgb word with no yuv word pending");
				end else begin
					want = expected_pairs.pop_front();
					check_channel("red_first", rgb.red_first, want.red_first);
					check_channel("green_first", rgb.green_first, want.green_first);
					check_channel("blue_first", rgb.blue_first, want.blue_first);
					check_channel("red_second", rgb.red_second, want.red_second);
					check_channel("green_second", rgb.green_second, want.green_second);
					check_channel("blue_second", rgb.blue_second, want.blue_second);
					if (rgb.frame_end_out !== want.frame_end)
						report_error($sformatf("frame_end_out got %b expected %b",
							rgb.frame_end_out, want.frame_end));
				end
			end
			if (yuv.valid && yuv.ready) begin
				taken.luma_first  = yuv.luma_first;
				taken.chroma_blue = yuv.chroma_blue;
				taken.luma_second = yuv.luma_second;
				taken.chroma_red  = yuv.chroma_red;
				taken.frame_end   = yuv.frame_end_in;
				expected_pairs.push_back(convert_word(taken));
			end
		end
	end

	// Abort when neither side moves a word for too long
	always @(posedge clk) begin
		if ((yuv.valid && yuv.ready) || (rgb.valid && rgb.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("yuyv_to_rgb_scaled: mismatch");
			$finish;
		end
	end

	initial begin
		arst_n           <= 1'b0;
		yuv.valid        <= 1'b0;
		yuv.luma_first   <= '0;
		yuv.chroma_blue  <= '0;
		yuv.luma_second  <= '0;
		yuv.chroma_red   <= '0;
		yuv.frame_end_in <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corner_words();
		test_back_to_back(60);
		test_output_hold(30);
		test_random_words(340);

		if (expected_pairs.size() != 0)
			report_error($sformatf("%0d rgb words never arrived", expected_pairs.size()));
		if (error_count == 0)
			$display("yuyv_to_rgb_scaled: match");
		else
			$display("yuyv_to_rgb_scaled: mismatch");
		$finish;
	end

endmodule
